[hdl/sjf_nonpreemptive_scheduler_macros.svh]
// ----------------------------------------------------------------------------
// SJF scheduler assertion macros
// Concurrent assertion wrappers; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef SJF_NONPREEMPTIVE_SCHEDULER_MACROS_SVH
`define SJF_NONPREEMPTIVE_SCHEDULER_MACROS_SVH

`ifndef SYNTHESIS
`define SJF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sjf scheduler: assertion failed");
`define SJF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sjf scheduler: assertion failed");
`else
`define SJF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SJF_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hdl/sjf_pkg.sv]
// ----------------------------------------------------------------------------
// SJF scheduler package
// Field widths, payload structs and cell chain types.
// ----------------------------------------------------------------------------
package sjf_pkg;

    localparam int MAX_JOBS_DEF = 16;
    localparam int ARR_W        = 16;
    localparam int BURST_W      = 16;
    localparam int TIME_W       = 21;
    localparam int JOB_IDX_W    = 4;

    typedef struct packed {
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic               final_job;
    } t_in_item;

    typedef struct packed {
        logic [JOB_IDX_W-1:0] job_index;
        logic [TIME_W-1:0]    finish_time;
        logic [TIME_W-1:0]    turnaround;
        logic [TIME_W-1:0]    wait_res;
        logic                 end_of_batch;
    } t_out_item;

    // partial result handed from cell to cell
    typedef struct packed {
        logic               found;
        logic [BURST_W-1:0] best;
        logic               any;
        logic [ARR_W-1:0]   next;
    } t_scan;

    typedef struct packed {
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic [TIME_W-1:0]  finish;
    } t_entry;

    typedef struct packed {
        logic               load_we;
        logic               clear;
        logic               commit;
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic [TIME_W-1:0]  finish;
    } t_cell_ctl;

endpackage

[hdl/sjf_cell.sv]
// ----------------------------------------------------------------------------
// SJF scheduler job cell
// Holds one job and folds it into the registered scan passed down the chain.
// ----------------------------------------------------------------------------
module sjf_cell import sjf_pkg::*; #(
    parameter int MAX_JOBS = MAX_JOBS_DEF,
    parameter int INDEX    = 0
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  t_cell_ctl                                      i_ctl,
    input  logic [$clog2(MAX_JOBS+1)-1:0]                  i_count,
    input  logic [((MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1)-1:0] i_commit_idx,
    input  logic [TIME_W-1:0]                              i_now,
    input  t_scan                                          i_scan,
    input  logic [((MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1)-1:0] i_pick,
    output t_scan                                          o_scan,
    output logic [((MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1)-1:0] o_pick,
    output t_entry                                         o_entry
);

    localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W = $clog2(MAX_JOBS + 1);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
    localparam logic [CNT_W-1:0] MY_POS = CNT_W'(INDEX);

    logic [ARR_W-1:0]   r_arr;
    logic [BURST_W-1:0] r_burst;
    logic [TIME_W-1:0]  r_finish;
    logic               r_done;
    t_scan              r_scan;
    logic [IDX_W-1:0]   r_pick;

    t_scan              n_scan;
    logic [IDX_W-1:0]   n_pick;
    logic               active;

    assign active = (MY_POS < i_count) && !r_done;

    always_comb begin
        n_scan = i_scan;
        n_pick = i_pick;
        if (active && (TIME_W'(r_arr) <= i_now) && (!i_scan.found || r_burst < i_scan.best)) begin
            n_scan.found = 1'b1;
            n_scan.best  = r_burst;
            n_pick       = MY_IDX;
        end
        if (active && (!i_scan.any || r_arr < i_scan.next)) begin
            n_scan.any  = 1'b1;
            n_scan.next = r_arr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
            r_scan <= '0;
            r_pick <= '0;
        end else begin
            r_scan <= n_scan;
            r_pick <= n_pick;
            if (i_ctl.clear || (i_ctl.load_we && i_count == MY_POS)) begin
                r_done <= 1'b0;
            end else if (i_ctl.commit && i_commit_idx == MY_IDX) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_we && i_count == MY_POS) begin
            r_arr   <= i_ctl.arrival;
            r_burst <= i_ctl.burst;
        end
        if (i_ctl.commit && i_commit_idx == MY_IDX) begin
            r_finish <= i_ctl.finish;
        end
    end

    assign o_scan          = r_scan;
    assign o_pick          = r_pick;
    assign o_entry.arrival = r_arr;
    assign o_entry.burst   = r_burst;
    assign o_entry.finish  = r_finish;

endmodule

[hdl/sjf_nonpreemptive_scheduler.sv]
// ----------------------------------------------------------------------------
// SJF non-preemptive scheduler
// Loads a batch of jobs, schedules shortest burst first, emits per-job times.
// ----------------------------------------------------------------------------
//  channel   | signals                              | moves
//  ----------+--------------------------------------+---------------------------
//  in        | i_in_valid, o_in_stall, i_in_data     | one job per transfer
//  out       | o_out_valid, i_out_stall, o_out_data  | one job result per transfer
//
//  Loading writes each job into the next free cell. Each decision runs a
//  registered scan down the chain of MAX_JOBS cells; a batch of N jobs
//  needs at most 2N decisions (a pick or an idle jump), then N results.
//  Reset is synchronous and clears control state only; no clearing pass.
//  Input is stalled while scheduling and emitting; a stalled result holds.
// ----------------------------------------------------------------------------
`include "sjf_nonpreemptive_scheduler_macros.svh"

module sjf_nonpreemptive_scheduler import sjf_pkg::*; #(
    parameter int MAX_JOBS = MAX_JOBS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W = $clog2(MAX_JOBS + 1);

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_cyc,   n_cyc;
    logic [CNT_W-1:0]  r_done,  n_done;
    logic [TIME_W-1:0] r_now,   n_now;
    logic [IDX_W-1:0]  r_k,     n_k;
    logic              r_ov,    n_ov;
    t_out_item         r_out,   n_out;

    t_cell_ctl         ctl;
    t_scan             w_scan  [MAX_JOBS];
    logic [IDX_W-1:0]  w_pick  [MAX_JOBS];
    t_entry            w_entry [MAX_JOBS];
    t_scan             w_tail;
    logic [IDX_W-1:0]  w_tail_pick;

    t_entry                      e_sel;
    logic [TIME_W-1:0]           tat;
    logic [TIME_W-1:0]           wt;
    logic                        last_k;
    logic                        out_take;
    logic                        scan_end;

    genvar g;
    generate
        for (g = 0; g < MAX_JOBS; g++) begin : g_cell
            if (g == 0) begin : g_head
                sjf_cell #(.MAX_JOBS(MAX_JOBS), .INDEX(g)) u_cell (
                    .i_clk        (i_clk),
                    .i_rst_n      (i_rst_n),
                    .i_ctl        (ctl),
                    .i_count      (r_count),
                    .i_commit_idx (w_tail_pick),
                    .i_now        (r_now),
                    .i_scan       ('0),
                    .i_pick       ('0),
                    .o_scan       (w_scan[g]),
                    .o_pick       (w_pick[g]),
                    .o_entry      (w_entry[g])
                );
            end else begin : g_body
                sjf_cell #(.MAX_JOBS(MAX_JOBS), .INDEX(g)) u_cell (
                    .i_clk        (i_clk),
                    .i_rst_n      (i_rst_n),
                    .i_ctl        (ctl),
                    .i_count      (r_count),
                    .i_commit_idx (w_tail_pick),
                    .i_now        (r_now),
                    .i_scan       (w_scan[g-1]),
                    .i_pick       (w_pick[g-1]),
                    .o_scan       (w_scan[g]),
                    .o_pick       (w_pick[g]),
                    .o_entry      (w_entry[g])
                );
            end
        end
    endgenerate

    assign w_tail      = w_scan[MAX_JOBS-1];
    assign w_tail_pick = w_pick[MAX_JOBS-1];

    assign e_sel    = w_entry[r_k];
    assign tat      = e_sel.finish - TIME_W'(e_sel.arrival);
    assign wt       = tat - TIME_W'(e_sel.burst);
    assign last_k   = (CNT_W'(r_k) + CNT_W'(1)) == r_count;
    assign out_take = !r_ov || !i_out_stall;
    assign scan_end = r_cyc == CNT_W'(MAX_JOBS);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_cyc   = r_cyc;
        n_done  = r_done;
        n_now   = r_now;
        n_k     = r_k;
        n_ov    = r_ov;
        n_out   = r_out;

        ctl         = '0;
        ctl.arrival = i_in_data.arrival;
        ctl.burst   = i_in_data.burst;
        ctl.finish  = r_now + TIME_W'(w_tail.best);

        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end

        case (r_state)
            ST_LOAD: begin
                if (i_in_valid) begin
                    if (r_count < CNT_W'(MAX_JOBS)) begin
                        ctl.load_we = 1'b1;
                        n_count     = r_count + CNT_W'(1);
                    end
                    if (i_in_data.final_job) begin
                        n_state = ST_SCAN;
                        n_cyc   = '0;
                        n_done  = '0;
                        n_now   = '0;
                    end
                end
            end
            ST_SCAN: begin
                if (!scan_end) begin
                    n_cyc = r_cyc + CNT_W'(1);
                end else begin
                    n_cyc = '0;
                    if (w_tail.found) begin
                        ctl.commit = 1'b1;
                        n_now      = ctl.finish;
                        n_done     = r_done + CNT_W'(1);
                        if ((r_done + CNT_W'(1)) == r_count) begin
                            n_state = ST_EMIT;
                            n_k     = '0;
                        end
                    end else if (w_tail.any) begin
                        n_now = TIME_W'(w_tail.next);
                    end else begin
                        n_state = ST_EMIT;
                        n_k     = '0;
                    end
                end
            end
            ST_EMIT: begin
                if (out_take) begin
                    n_ov                = 1'b1;
                    n_out.job_index     = JOB_IDX_W'(r_k);
                    n_out.finish_time   = e_sel.finish;
                    n_out.turnaround    = tat;
                    n_out.wait_res      = wt;
                    n_out.end_of_batch  = last_k;
                    if (last_k) begin
                        ctl.clear = 1'b1;
                        n_count   = '0;
                        n_now     = '0;
                        n_state   = ST_LOAD;
                    end else begin
                        n_k = r_k + IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_cyc   <= '0;
            r_done  <= '0;
            r_now   <= '0;
            r_k     <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_cyc   <= n_cyc;
            r_done  <= n_done;
            r_now   <= n_now;
            r_k     <= n_k;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_in_stall  = r_state != ST_LOAD;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    `SJF_ASSERT_IMP(a_done_below_count, i_clk, i_rst_n, r_state == ST_SCAN, r_done < r_count)
    `SJF_ASSERT_IMP(a_pick_has_arrived, i_clk, i_rst_n, (r_state == ST_SCAN && scan_end && w_tail.found), (TIME_W'(w_entry[w_tail_pick].arrival) <= r_now))
    `SJF_ASSERT_NXT(a_batch_cleared, i_clk, i_rst_n, (r_state == ST_EMIT && out_take && last_k), (r_count == '0 && r_now == '0))

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SJF non-preemptive scheduler testbench
// Loads batches of jobs over the input channel and predicts, per batch, the
// shortest-burst-first order with lowest-index tie break and idle jumps to the
// next arrival. Each result transfer is checked field by field against the
// oldest predicted result. A short directed table covers single jobs at the
// field extremes, an idle jump, a burst tie and store overflow; random batches
// with random idle and stall bursts follow.
// ----------------------------------------------------------------------------
module tb_top;
    import sjf_pkg::*;

    localparam int TOTAL_JOBS   = 310;
    localparam int CALM_JOBS    = 40;
    localparam int STALL_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 40;
    localparam int REPORT_LIMIT = 10;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;

    // job store of the predicted batch
    logic [ARR_W-1:0]   job_arrival [MAX_JOBS_DEF];
    logic [BURST_W-1:0] job_burst   [MAX_JOBS_DEF];
    logic [TIME_W-1:0]  job_finish  [MAX_JOBS_DEF];
    logic               job_done    [MAX_JOBS_DEF];
    int                 job_total;

    t_out_item pending_results[$];

    t_in_item  dir_item[$];
    logic      dir_typed[$];
    t_out_item dir_want[$];
    int        batch_row0;

    int  jobs_sent;
    int  batches_run;
    int  jobs_dropped;
    int  results_seen;
    int  fault_count;
    int  quiet_cycles;
    int  hold_left;
    bit  calm;

    sjf_nonpreemptive_scheduler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #2 i_clk = ~i_clk;

    task automatic predict_job(input t_in_item job);
        logic [TIME_W-1:0]  now_t;
        logic [TIME_W-1:0]  span;
        logic [BURST_W-1:0] best;
        logic [ARR_W-1:0]   next_arr;
        logic               found;
        logic               any;
        int                 pick;
        int                 n_done;
        t_out_item          res;
        if (job_total < MAX_JOBS_DEF) begin
            job_arrival[job_total] = job.arrival;
            job_burst[job_total]   = job.burst;
            job_done[job_total]    = 1'b0;
            job_total++;
        end else begin
            jobs_dropped++;
        end
        if (!job.final_job) return;

        now_t  = '0;
        n_done = 0;
        while (n_done < job_total) begin
            found = 1'b0;
            best  = '0;
            pick  = 0;
            for (int i = 0; i < job_total; i++) begin
                span = {{(TIME_W-ARR_W){1'b0}}, job_arrival[i]};
                if (!job_done[i] && span <= now_t && (!found || job_burst[i] < best)) begin
                    found = 1'b1;
                    best  = job_burst[i];
                    pick  = i;
                end
            end
            if (found) begin
                now_t = now_t + {{(TIME_W-BURST_W){1'b0}}, job_burst[pick]};
                job_finish[pick] = now_t;
                job_done[pick]   = 1'b1;
                n_done++;
            end else begin
                any      = 1'b0;
                next_arr = '0;
                for (int i = 0; i < job_total; i++) begin
                    if (!job_done[i] && (!any || job_arrival[i] < next_arr)) begin
                        any      = 1'b1;
                        next_arr = job_arrival[i];
                    end
                end
                now_t = {{(TIME_W-ARR_W){1'b0}}, next_arr};
            end
        end

        for (int i = 0; i < job_total; i++) begin
            res.job_index    = JOB_IDX_W'(i);
            res.finish_time  = job_finish[i];
            res.turnaround   = job_finish[i] - {{(TIME_W-ARR_W){1'b0}}, job_arrival[i]};
            res.wait_res     = res.turnaround - {{(TIME_W-BURST_W){1'b0}}, job_burst[i]};
            res.end_of_batch = (i == job_total - 1);
            pending_results.push_back(res);
        end
        for (int i = 0; i < MAX_JOBS_DEF; i++) job_done[i] = 1'b0;
        job_total = 0;
        batches_run++;
    endtask

    task automatic note_fault(input string what, input t_out_item want, input t_out_item got);
        fault_count++;
        if (fault_count <= REPORT_LIMIT) begin
            $display("ERROR %s at %0t: expected idx=%0d fin=%0d tat=%0d wt=%0d eob=%0b",
                     what, $time, want.job_index, want.finish_time, want.turnaround,
                     want.wait_res, want.end_of_batch);
            $display("      got idx=%0d fin=%0d tat=%0d wt=%0d eob=%0b",
                     got.job_index, got.finish_time, got.turnaround, got.wait_res,
                     got.end_of_batch);
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (pending_results.size() == 0) begin
            note_fault("unexpected result", '0, got);
            return;
        end
        want = pending_results.pop_front();
        results_seen++;
        if (got.job_index !== want.job_index || got.finish_time !== want.finish_time ||
            got.turnaround !== want.turnaround || got.wait_res !== want.wait_res ||
            got.end_of_batch !== want.end_of_batch)
            note_fault("result mismatch", want, got);
    endtask

    // present one job, hold it until the transfer, then predict
    task automatic push_job(input t_in_item job, input int row);
        int gap;
        int base;
        if (!calm && $urandom_range(0, 99) < 25) begin
            gap = $urandom_range(1, 10);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= job;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        base = pending_results.size();
        predict_job(job);
        if (row >= 0) begin
            for (int k = base; k < pending_results.size(); k++)
                if (dir_typed[batch_row0 + k - base])
                    pending_results[k] = dir_want[batch_row0 + k - base];
            if (job.final_job) batch_row0 = row + 1;
        end
        jobs_sent++;
        if (jobs_sent >= TOTAL_JOBS - CALM_JOBS) calm = 1'b1;
        @(negedge i_clk);
    endtask

    task automatic add_row(input logic [ARR_W-1:0] arr, input logic [BURST_W-1:0] bur,
                           input logic last, input logic typed, input t_out_item want);
        t_in_item job;
        job.arrival   = arr;
        job.burst     = bur;
        job.final_job = last;
        dir_item.push_back(job);
        dir_typed.push_back(typed);
        dir_want.push_back(want);
    endtask

    task automatic send_random_batch();
        int       n;
        int       amode;
        int       bmode;
        t_in_item job;
        case ($urandom_range(0, 9))
            0:       n = $urandom_range(17, 20);
            1, 2:    n = $urandom_range(1, 3);
            default: n = $urandom_range(4, 16);
        endcase
        amode = $urandom_range(0, 3);
        bmode = $urandom_range(0, 3);
        for (int k = 0; k < n; k++) begin
            case (amode)
                0:       job.arrival = 16'($urandom_range(0, 24));
                1:       job.arrival = 16'($urandom);
                2:       job.arrival = $urandom_range(0, 1) ? 16'hFFFF
                                                            : 16'($urandom_range(0, 3));
                default: job.arrival = 16'(k * $urandom_range(0, 4000));
            endcase
            case (bmode)
                0:       job.burst = 16'($urandom_range(0, 3));
                1:       job.burst = 16'($urandom);
                2:       job.burst = 16'($urandom_range(0, 200));
                default: job.burst = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            endcase
            job.final_job = (k == n - 1);
            push_job(job, -1);
        end
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n || calm) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
        end else if (!i_out_stall && $urandom_range(0, 3) == 0) begin
            i_out_stall <= 1'b1;
            hold_left = $urandom_range(0, 9);
        end else begin
            i_out_stall <= 1'b0;
            hold_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 150)
                                                    : $urandom_range(0, 6);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                check_result(o_out_data);
                quiet_cycles = 0;
            end else if (i_in_valid && o_in_stall === 1'b0) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("sjf_nonpreemptive_scheduler: mismatch");
                $finish;
            end
        end
    end

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        i_out_stall  = 1'b0;
        job_total    = 0;
        batch_row0   = 0;
        jobs_sent    = 0;
        batches_run  = 0;
        jobs_dropped = 0;
        results_seen = 0;
        fault_count  = 0;
        quiet_cycles = 0;
        hold_left    = 0;
        calm         = 1'b0;
        for (int i = 0; i < MAX_JOBS_DEF; i++) job_done[i] = 1'b0;

        // single jobs: all zero, both fields at maximum, late arrival
        add_row(16'd0, 16'd0, 1'b1, 1'b1, {4'd0, 21'd0, 21'd0, 21'd0, 1'b1});
        add_row(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, {4'd0, 21'd131070, 21'd65535, 21'd0, 1'b1});
        add_row(16'd100, 16'd5, 1'b1, 1'b1, {4'd0, 21'd105, 21'd5, 21'd0, 1'b1});
        // equal bursts, shorter job loaded last
        add_row(16'd0, 16'd10, 1'b0, 1'b0, '0);
        add_row(16'd0, 16'd10, 1'b0, 1'b0, '0);
        add_row(16'd0, 16'd3, 1'b1, 1'b0, '0);
        // full store, then a plain and a final job that both get dropped
        for (int k = 0; k < MAX_JOBS_DEF; k++)
            add_row(16'(k * 4369), 16'hFFFF - 16'(k * 4096), 1'b0, 1'b0, '0);
        add_row(16'd7, 16'd7, 1'b0, 1'b0, '0);
        add_row(16'd9, 16'd9, 1'b1, 1'b0, '0);

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < dir_item.size(); r++) push_job(dir_item[r], r);
        while (jobs_sent < TOTAL_JOBS) send_random_batch();
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d jobs in %0d batches, %0d dropped on a full store",
                 jobs_sent, batches_run, jobs_dropped);
        $display("checked %0d job results, %0d faults", results_seen, fault_count);
        if (fault_count == 0) begin
            $display("sjf_nonpreemptive_scheduler: match");
        end else begin
            $display("sjf_nonpreemptive_scheduler: mismatch");
        end
        $finish;
    end

endmodule
